/* hw/rtl/bmh_pkg.sv */
`default_nettype none

package bmh_pkg;

  localparam int MAX_ORDER   = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int NUM_CLASSES = 3;

  localparam int TABLE_SIZE = (1 << (MAX_ORDER + 1)) - 2;
  localparam int IDX_W      = MAX_ORDER + 1;
  localparam int RUN_W      = $clog2(MAX_ORDER + 1);
  localparam int LEN_W      = $clog2(MAX_ORDER + 2);

  localparam int ORD_W  = 4;
  localparam int SYM_W  = 2;
  localparam int CLS_W  = 2;
  localparam int OUT_W  = 32;

  localparam logic [ORD_W-1:0] ORDER_RESET = 4'd4;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 2'd0;
  localparam logic [SYM_W-1:0] SYM_MINUS = 2'd1;
  localparam logic [CLS_W-1:0] CLS_NONE  = 2'd3;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef struct packed {
    cnt_t                   count;
    cnt_t [NUM_CLASSES-1:0] cls;
  } row_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic issue_rd;
    logic issue_upd;
    logic wb;
    logic load_out;
  } bmh_cmd_t;

  typedef struct packed {
    logic more;
    logic clear_last;
  } bmh_status_t;

  function automatic cnt_t sat_inc(cnt_t x);
    return (&x) ? x : x + cnt_t'(1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bmh_intf.sv */
`default_nettype none

interface bmh_in_if import bmh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SYM_W-1:0]   symbol;
  logic [CLS_W-1:0]   spectrum_class;
  logic               new_sequence;
  logic [IDX_W-1:0]   read_index;

  modport source (output valid, cmd, symbol, spectrum_class, new_sequence, read_index,
                  input ready);
  modport sink (input valid, cmd, symbol, spectrum_class, new_sequence, read_index,
                output ready);
endinterface

interface bmh_out_if import bmh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] entry_count;
  logic [OUT_W-1:0] entry_class_zero;
  logic [OUT_W-1:0] entry_class_one;
  logic [OUT_W-1:0] entry_class_two;
  logic [OUT_W-1:0] total_plus;
  logic [OUT_W-1:0] total_minus;
  logic [OUT_W-1:0] total_undefined;
  logic [OUT_W-1:0] total_up;
  logic [OUT_W-1:0] total_down;

  modport source (output valid, entry_count, entry_class_zero, entry_class_one,
                  entry_class_two, total_plus, total_minus, total_undefined, total_up,
                  total_down, input ready);
  modport sink (input valid, entry_count, entry_class_zero, entry_class_one,
                entry_class_two, total_plus, total_minus, total_undefined, total_up,
                total_down, output ready);
endinterface

`default_nettype wire

/* hw/rtl/binary_motif_histogram.sv */
// Channel  Modport        Direction  Accepted when
// in_i     bmh_in_if      input      in_i.valid && in_i.ready
// out_o    bmh_out_if     output     out_o.valid && out_o.ready
// cfg      cfg_we_i       input      cfg_we_i high, order in cfg_wdata_i
//
// After reset a clearing pass writes all 510 table rows, one per cycle; no item is taken.
// A record reads and writes back one table row per cycle through the single row memory;
// the write-back of each row happens in the same cycle as the read of the next row.
// One item is in work at a time.
// The next item is accepted while a finished result waits in the output register.
`default_nettype none

module binary_motif_histogram import bmh_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire [ORD_W-1:0] cfg_wdata_i,
  bmh_in_if.sink          in_i,
  bmh_out_if.source       out_o
);

  bmh_cmd_t    cmd;
  bmh_status_t status;
  logic        in_ready;
  logic        out_valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  bmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  bmh_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_cmd_i           (in_i.cmd),
    .in_symbol_i        (in_i.symbol),
    .in_class_i         (in_i.spectrum_class),
    .in_new_seq_i       (in_i.new_sequence),
    .in_read_index_i    (in_i.read_index),
    .entry_count_o      (out_o.entry_count),
    .entry_class_zero_o (out_o.entry_class_zero),
    .entry_class_one_o  (out_o.entry_class_one),
    .entry_class_two_o  (out_o.entry_class_two),
    .total_plus_o       (out_o.total_plus),
    .total_minus_o      (out_o.total_minus),
    .total_undefined_o  (out_o.total_undefined),
    .total_up_o         (out_o.total_up),
    .total_down_o       (out_o.total_down)
  );

endmodule

`default_nettype wire

/* hw/rtl/bmh_ctrl.sv */
`default_nettype none

module bmh_ctrl import bmh_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_cmd_i,
  input  wire         out_ready_i,
  input  bmh_status_t status_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output bmh_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   pend_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.clear_wr  = (state_q == ST_CLEAR);
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue_rd  = (state_q == ST_READ);
    cmd_o.issue_upd = (state_q == ST_UPD) && status_i.more;
    cmd_o.wb        = (state_q == ST_UPD) && pend_q;
    cmd_o.load_out  = (state_q == ST_FIN) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ((state_q == ST_FIN) && slot_free) || (out_valid_q && !out_ready_i);
      pend_q      <= (state_q == ST_UPD) && status_i.more;
      unique case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= (in_cmd_i == CMD_READ) ? ST_READ : ST_UPD;
          end
        end
        ST_READ: begin
          state_q <= ST_FIN;
        end
        ST_UPD: begin
          if (!status_i.more) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_wb_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> $past(cmd_o.issue_upd))
    else $error("Write-back without a preceding table read.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("Result register overwritten before it was taken.");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_wr |-> !cmd_o.accept && !cmd_o.wb)
    else $error("Table access during the clearing pass.");

endmodule

`default_nettype wire

/* hw/rtl/bmh_datapath.sv */
`default_nettype none

module bmh_datapath import bmh_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  bmh_cmd_t         cmd_i,
  output bmh_status_t      status_o,
  input  wire              cfg_we_i,
  input  wire [ORD_W-1:0]  cfg_wdata_i,
  input  wire              in_cmd_i,
  input  wire [SYM_W-1:0]  in_symbol_i,
  input  wire [CLS_W-1:0]  in_class_i,
  input  wire              in_new_seq_i,
  input  wire [IDX_W-1:0]  in_read_index_i,
  output logic [OUT_W-1:0] entry_count_o,
  output logic [OUT_W-1:0] entry_class_zero_o,
  output logic [OUT_W-1:0] entry_class_one_o,
  output logic [OUT_W-1:0] entry_class_two_o,
  output logic [OUT_W-1:0] total_plus_o,
  output logic [OUT_W-1:0] total_minus_o,
  output logic [OUT_W-1:0] total_undefined_o,
  output logic [OUT_W-1:0] total_up_o,
  output logic [OUT_W-1:0] total_down_o
);

  row_t row_mem [TABLE_SIZE];

  logic [ORD_W-1:0]     order_q;
  logic [MAX_ORDER-1:0] hist_q, hist_d, hist_base;
  logic [RUN_W-1:0]     run_q, run_d, run_base, ord_eff;
  logic                 have_prev_q, have_prev_d, have_prev_base;
  logic                 prev_minus_q, prev_minus_d;
  cnt_t                 plus_q, minus_q, undef_q, up_q, down_q;
  logic [LEN_W-1:0]     len_q;
  logic [IDX_W-1:0]     clr_q, waddr_q, ridx_q, upd_idx, pow;
  logic [MAX_ORDER:0]   mask_w;
  logic [CLS_W-1:0]     cls_q;
  logic                 is_read_q, in_range_q, rd_en;
  logic                 defined, minus;
  row_t                 rdata_q, wb_row;

  always_comb begin
    if (order_q == '0) begin
      ord_eff = RUN_W'(1);
    end else if (int'(order_q) > MAX_ORDER) begin
      ord_eff = RUN_W'(MAX_ORDER);
    end else begin
      ord_eff = RUN_W'(order_q);
    end
    mask_w = ({{MAX_ORDER{1'b0}}, 1'b1} << ord_eff) - 1'b1;

    hist_base      = in_new_seq_i ? '0 : hist_q;
    run_base       = in_new_seq_i ? '0 : run_q;
    have_prev_base = in_new_seq_i ? 1'b0 : have_prev_q;
    defined        = (in_symbol_i == SYM_PLUS) || (in_symbol_i == SYM_MINUS);
    minus          = (in_symbol_i == SYM_MINUS);

    if (defined) begin
      hist_d       = {hist_base[MAX_ORDER-2:0], minus} & mask_w[MAX_ORDER-1:0];
      run_d        = (run_base >= ord_eff) ? ord_eff : run_base + RUN_W'(1);
      have_prev_d  = 1'b1;
      prev_minus_d = minus;
    end else begin
      hist_d       = '0;
      run_d        = '0;
      have_prev_d  = 1'b0;
      prev_minus_d = prev_minus_q;
    end
  end

  always_comb begin
    pow     = {{(IDX_W-1){1'b0}}, 1'b1} << len_q;
    upd_idx = pow - IDX_W'(2) + (IDX_W'(hist_q) & (pow - IDX_W'(1)));
  end

  assign status_o.more       = (len_q <= LEN_W'(run_q));
  assign status_o.clear_last = (clr_q == IDX_W'(TABLE_SIZE - 1));

  assign rd_en = cmd_i.issue_upd || (cmd_i.issue_rd && (int'(ridx_q) < TABLE_SIZE));

  always_comb begin
    wb_row       = rdata_q;
    wb_row.count = sat_inc(rdata_q.count);
    if (cls_q != CLS_NONE) begin
      wb_row.cls[cls_q] = sat_inc(rdata_q.cls[cls_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_wr) begin
      row_mem[clr_q] <= '0;
    end else if (cmd_i.wb) begin
      row_mem[waddr_q] <= wb_row;
    end
    if (rd_en) begin
      rdata_q <= row_mem[cmd_i.issue_upd ? upd_idx : ridx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ridx_q    <= in_read_index_i;
      cls_q     <= in_class_i;
      is_read_q <= (in_cmd_i == CMD_READ);
    end
    if (cmd_i.issue_upd) begin
      waddr_q <= upd_idx;
    end
    if (cmd_i.issue_rd) begin
      in_range_q <= (int'(ridx_q) < TABLE_SIZE);
    end
    if (cmd_i.load_out) begin
      if (is_read_q && in_range_q) begin
        entry_count_o      <= OUT_W'(rdata_q.count);
        entry_class_zero_o <= OUT_W'(rdata_q.cls[0]);
        entry_class_one_o  <= OUT_W'(rdata_q.cls[1]);
        entry_class_two_o  <= OUT_W'(rdata_q.cls[2]);
      end else begin
        entry_count_o      <= '0;
        entry_class_zero_o <= '0;
        entry_class_one_o  <= '0;
        entry_class_two_o  <= '0;
      end
      total_plus_o      <= OUT_W'(plus_q);
      total_minus_o     <= OUT_W'(minus_q);
      total_undefined_o <= OUT_W'(undef_q);
      total_up_o        <= OUT_W'(up_q);
      total_down_o      <= OUT_W'(down_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q      <= ORDER_RESET;
      hist_q       <= '0;
      run_q        <= '0;
      have_prev_q  <= 1'b0;
      prev_minus_q <= 1'b0;
      plus_q       <= '0;
      minus_q      <= '0;
      undef_q      <= '0;
      up_q         <= '0;
      down_q       <= '0;
      len_q        <= '0;
      clr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.issue_upd) begin
        len_q <= len_q + LEN_W'(1);
      end
      if (cmd_i.accept) begin
        len_q <= LEN_W'(1);
        if (in_cmd_i == CMD_RECORD) begin
          hist_q       <= hist_d;
          run_q        <= run_d;
          have_prev_q  <= have_prev_d;
          prev_minus_q <= prev_minus_d;
          if (!defined) begin
            undef_q <= sat_inc(undef_q);
          end else if (minus) begin
            minus_q <= sat_inc(minus_q);
            if (have_prev_base && !prev_minus_q) begin
              up_q <= sat_inc(up_q);
            end
          end else begin
            plus_q <= sat_inc(plus_q);
            if (have_prev_base && prev_minus_q) begin
              down_q <= sat_inc(down_q);
            end
          end
        end
      end
    end
  end

  a_len_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_upd |-> (int'(len_q) <= MAX_ORDER) && (len_q != '0))
    else $error("Motif length outside the table.");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wb && cmd_i.issue_upd) |-> (upd_idx != waddr_q))
    else $error("Read and write-back hit the same table row.");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (int'(run_q) <= MAX_ORDER))
    else $error("Run length beyond the largest order.");

endmodule

`default_nettype wire
